### design/mission_status_sequence_filter_assert.svh
// assertion helpers for the checker file
`ifndef MISSION_STATUS_SEQUENCE_FILTER_ASSERT_SVH
`define MISSION_STATUS_SEQUENCE_FILTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define MSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define MSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/msf_pkg.sv
`default_nettype none
package msf_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_STATUS = 2'd1,
    OP_START  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SESSION_EPOCH = 3'd0,
    REG_FRESH_LIMIT   = 3'd1,
    REG_READY_CODE    = 3'd2,
    REG_MIN_MISSION   = 3'd3,
    REG_MAX_MISSION   = 3'd4
  } reg_idx_t;

  // event counter slots
  localparam logic [1:0] CNT_ACCEPTED     = 2'd0;
  localparam logic [1:0] CNT_DUPLICATE    = 2'd1;
  localparam logic [1:0] CNT_OUT_OF_ORDER = 2'd2;
  localparam logic [1:0] CNT_MISMATCH     = 2'd3;

  localparam logic [7:0]  DEFAULT_MISSION   = 8'd2;
  localparam logic [15:0] RST_SESSION_EPOCH = 16'd1;
  localparam logic [15:0] RST_FRESH_LIMIT   = 16'd100;
  localparam logic [7:0]  RST_READY_CODE    = 8'd1;
  localparam logic [7:0]  RST_MIN_MISSION   = 8'd1;
  localparam logic [7:0]  RST_MAX_MISSION   = 8'd8;

  typedef struct packed {
    logic [15:0] session_epoch;
    logic [15:0] fresh_limit_ms;
    logic [7:0]  ready_state_code;
    logic [7:0]  min_mission_id;
    logic [7:0]  max_mission_id;
  } cfg_t;

  typedef struct packed {
    logic        op_ok;
    logic        is_ready;
    logic        command_code;
    logic [7:0]  chosen_mission;
    logic [15:0] intent_epoch;
    logic [31:0] cmd_time_ms;
    logic [31:0] accepted_count;
    logic [31:0] duplicate_count;
    logic [31:0] out_of_order_count;
    logic [31:0] mismatch_count;
  } res_t;

  // ready: valid status, no start yet, ready state code, age within limit
  function automatic logic ready_at(input logic        stat_valid,
                                    input logic        started,
                                    input logic [7:0]  stat_state,
                                    input logic [31:0] stat_time,
                                    input logic [31:0] now,
                                    input cfg_t        c);
    logic [31:0] age;
    age = now - stat_time;
    return stat_valid && !started && (stat_state == c.ready_state_code)
        && (age <= {16'd0, c.fresh_limit_ms});
  endfunction

endpackage
`default_nettype wire

### design/msf_regs.sv
`default_nettype none
module msf_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [msf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [msf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [msf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output msf_pkg::cfg_t                        cfg
);
  import msf_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SESSION_EPOCH: cfg_nxt.session_epoch    = pwdata[15:0];
        REG_FRESH_LIMIT:   cfg_nxt.fresh_limit_ms   = pwdata[15:0];
        REG_READY_CODE:    cfg_nxt.ready_state_code = pwdata[7:0];
        REG_MIN_MISSION:   cfg_nxt.min_mission_id   = pwdata[7:0];
        REG_MAX_MISSION:   cfg_nxt.max_mission_id   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SESSION_EPOCH: prdata = {16'd0, cfg_r.session_epoch};
      REG_FRESH_LIMIT:   prdata = {16'd0, cfg_r.fresh_limit_ms};
      REG_READY_CODE:    prdata = {24'd0, cfg_r.ready_state_code};
      REG_MIN_MISSION:   prdata = {24'd0, cfg_r.min_mission_id};
      REG_MAX_MISSION:   prdata = {24'd0, cfg_r.max_mission_id};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.session_epoch    <= RST_SESSION_EPOCH;
      cfg_r.fresh_limit_ms   <= RST_FRESH_LIMIT;
      cfg_r.ready_state_code <= RST_READY_CODE;
      cfg_r.min_mission_id   <= RST_MIN_MISSION;
      cfg_r.max_mission_id   <= RST_MAX_MISSION;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### design/mission_status_sequence_filter.sv
// Mission status sequence filter. Each input transaction carries one
// operation (select mission, status message, start request, query) and
// produces exactly one result transaction reporting op_ok, the ready flag,
// the current intent (command, mission, epoch, command time) and four
// wrapping event counters. Status messages must match the session epoch and
// the chosen mission; after the first accepted status, an 8-bit serial
// number filter drops duplicates (delta 0) and stale sequences (delta 128 or
// more). Throughput is one transaction per clock while the output side is
// not stalled: the item is captured in an input register, all decisions and
// state updates are done in one short combinational pass, and the result
// lands in an output register. A stall on the output holds the result
// register and, once the input register is also full, stalls the input.
// Configuration sits behind an APB port (registers at byte offsets
// 0x00..0x10, pready always high) and must only be written while no
// transaction is in flight.
`default_nettype none
module mission_status_sequence_filter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_operation,
  input  wire logic [7:0]                      in_mission_id,
  input  wire logic [15:0]                     in_status_epoch,
  input  wire logic [7:0]                      in_status_sequence,
  input  wire logic [7:0]                      in_status_state,
  input  wire logic [31:0]                     in_now_ms,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_op_ok,
  output logic                                 out_is_ready,
  output logic                                 out_command_code,
  output logic      [7:0]                      out_chosen_mission,
  output logic      [15:0]                     out_intent_epoch,
  output logic      [31:0]                     out_cmd_time_ms,
  output logic      [31:0]                     out_accepted_count,
  output logic      [31:0]                     out_duplicate_count,
  output logic      [31:0]                     out_out_of_order_count,
  output logic      [31:0]                     out_mismatch_count,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [msf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [msf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [msf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import msf_pkg::*;

  cfg_t cfg;

  msf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  op_t         s1_op_r;
  logic [7:0]  s1_mission_r;
  logic [15:0] s1_epoch_r;
  logic [7:0]  s1_seq_r;
  logic [7:0]  s1_state_r;
  logic [31:0] s1_now_r;

  logic        in_take;   // input transaction accepted this edge
  logic        adv;       // s1 item is processed and moves to the result reg

  logic        out_valid_r;
  logic        out_valid_nxt;
  res_t        res_r;
  res_t        res_nxt;

  // result register free, or being drained this cycle
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // client state
  // ---------------------------------------------------------------------
  logic [7:0]  mission_r,    mission_nxt;
  logic        cmd_r,        cmd_nxt;       // 0 prepare, 1 start
  logic [31:0] cmd_time_r,   cmd_time_nxt;
  logic        started_r,    started_nxt;   // sticky until reset
  logic        stat_valid_r, stat_valid_nxt;
  logic [7:0]  last_seq_r,   last_seq_nxt;
  logic [7:0]  last_state_r, last_state_nxt;
  logic [31:0] last_time_r,  last_time_nxt;
  logic [31:0] cnt_r   [4];
  logic [31:0] cnt_nxt [4];

  logic [7:0]  seq_delta;
  logic        ready_cur;
  logic        ready_post;
  logic        op_ok;
  logic        id_in_range;
  logic        stat_match;

  // serial number arithmetic on the 8-bit sequence
  assign seq_delta   = s1_seq_r - last_seq_r;
  assign id_in_range = (s1_mission_r >= cfg.min_mission_id)
                    && (s1_mission_r <= cfg.max_mission_id);
  assign stat_match  = (s1_epoch_r == cfg.session_epoch)
                    && (s1_mission_r == mission_r);
  assign ready_cur   = ready_at(stat_valid_r, started_r, last_state_r,
                                last_time_r, s1_now_r, cfg);

  always_comb begin
    mission_nxt    = mission_r;
    cmd_nxt        = cmd_r;
    cmd_time_nxt   = cmd_time_r;
    started_nxt    = started_r;
    stat_valid_nxt = stat_valid_r;
    last_seq_nxt   = last_seq_r;
    last_state_nxt = last_state_r;
    last_time_nxt  = last_time_r;
    cnt_nxt        = cnt_r;
    op_ok          = 1'b0;

    case (s1_op_r)
      OP_SELECT: begin
        // refused once a start was granted or when the id is out of range
        if (!started_r && id_in_range) begin
          mission_nxt    = s1_mission_r;
          cmd_nxt        = 1'b0;
          cmd_time_nxt   = s1_now_r;
          stat_valid_nxt = 1'b0;
          op_ok          = 1'b1;
        end
      end
      OP_STATUS: begin
        // mismatch is checked ahead of the sequence filter
        if (!stat_match) begin
          cnt_nxt[CNT_MISMATCH] = cnt_r[CNT_MISMATCH] + 32'd1;
        end else if (stat_valid_r && (seq_delta == 8'd0)) begin
          cnt_nxt[CNT_DUPLICATE] = cnt_r[CNT_DUPLICATE] + 32'd1;
        end else if (stat_valid_r && seq_delta[7]) begin
          cnt_nxt[CNT_OUT_OF_ORDER] = cnt_r[CNT_OUT_OF_ORDER] + 32'd1;
        end else begin
          last_seq_nxt          = s1_seq_r;
          last_state_nxt        = s1_state_r;
          last_time_nxt         = s1_now_r;
          stat_valid_nxt        = 1'b1;
          cnt_nxt[CNT_ACCEPTED] = cnt_r[CNT_ACCEPTED] + 32'd1;
          op_ok                 = 1'b1;
        end
      end
      OP_START: begin
        if (ready_cur) begin
          cmd_nxt      = 1'b1;
          cmd_time_nxt = s1_now_r;
          started_nxt  = 1'b1;
          op_ok        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ready as seen after this item, at its own timestamp
  assign ready_post = ready_at(stat_valid_nxt, started_nxt, last_state_nxt,
                               last_time_nxt, s1_now_r, cfg);

  always_comb begin
    res_nxt.op_ok              = (s1_op_r == OP_QUERY) ? ready_post : op_ok;
    res_nxt.is_ready           = ready_post;
    res_nxt.command_code       = cmd_nxt;
    res_nxt.chosen_mission     = mission_nxt;
    res_nxt.intent_epoch       = cfg.session_epoch;
    res_nxt.cmd_time_ms        = cmd_time_nxt;
    res_nxt.accepted_count     = cnt_nxt[CNT_ACCEPTED];
    res_nxt.duplicate_count    = cnt_nxt[CNT_DUPLICATE];
    res_nxt.out_of_order_count = cnt_nxt[CNT_OUT_OF_ORDER];
    res_nxt.mismatch_count     = cnt_nxt[CNT_MISMATCH];
  end

  // control and client state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      mission_r    <= DEFAULT_MISSION;
      cmd_r        <= 1'b0;
      cmd_time_r   <= '0;
      started_r    <= 1'b0;
      stat_valid_r <= 1'b0;
      last_seq_r   <= '0;
      last_state_r <= '0;
      last_time_r  <= '0;
      cnt_r[CNT_ACCEPTED]     <= '0;
      cnt_r[CNT_DUPLICATE]    <= '0;
      cnt_r[CNT_OUT_OF_ORDER] <= '0;
      cnt_r[CNT_MISMATCH]     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // state only moves when the item in s1 is actually processed
      if (adv) begin
        mission_r    <= mission_nxt;
        cmd_r        <= cmd_nxt;
        cmd_time_r   <= cmd_time_nxt;
        started_r    <= started_nxt;
        stat_valid_r <= stat_valid_nxt;
        last_seq_r   <= last_seq_nxt;
        last_state_r <= last_state_nxt;
        last_time_r  <= last_time_nxt;
        cnt_r        <= cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r      <= op_t'(in_operation);
      s1_mission_r <= in_mission_id;
      s1_epoch_r   <= in_status_epoch;
      s1_seq_r     <= in_status_sequence;
      s1_state_r   <= in_status_state;
      s1_now_r     <= in_now_ms;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_op_ok              = res_r.op_ok;
  assign out_is_ready           = res_r.is_ready;
  assign out_command_code       = res_r.command_code;
  assign out_chosen_mission     = res_r.chosen_mission;
  assign out_intent_epoch       = res_r.intent_epoch;
  assign out_cmd_time_ms        = res_r.cmd_time_ms;
  assign out_accepted_count     = res_r.accepted_count;
  assign out_duplicate_count    = res_r.duplicate_count;
  assign out_out_of_order_count = res_r.out_of_order_count;
  assign out_mismatch_count     = res_r.mismatch_count;

endmodule
`default_nettype wire

### design/msf_checker.sv
`default_nettype none
`include "mission_status_sequence_filter_assert.svh"
module msf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_is_ready,
  input wire logic        out_command_code,
  input wire logic [31:0] out_accepted_count
);

  // a started client is never ready
  `MSF_ASSERT_SAME(a_ready_not_started, out_valid && out_is_ready, !out_command_code, "ready while command is start")

  // two-stage pipe (input register, result register): an accepted item is followed by a valid result
  `MSF_ASSERT_SAME(a_result_latency, in_valid && !in_stall, ##2 out_valid, "no result two cycles after input transaction")

  // a stalled result stays
  `MSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `MSF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_accepted_count), "stalled result changed")

endmodule

bind mission_status_sequence_filter msf_checker u_msf_checker (.*);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import msf_pkg::*;

  // longest run of cycles with no transaction on any port before giving up
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 345;
  localparam int unsigned TAIL_ITEMS = 150;

  // one input transaction, fields at the block's widths
  typedef struct packed {
    op_t         op;
    logic [7:0]  mission;
    logic [15:0] epoch;
    logic [7:0]  seq;
    logic [7:0]  state;
    logic [31:0] now;
  } txn_t;

  // directed row: ok/ready are typed in only where they are obvious
  typedef struct {
    txn_t t;
    bit   typed;
    bit   ok;
    bit   rdy;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_mission_id = '0;
  logic [15:0] in_status_epoch = '0;
  logic [7:0]  in_status_sequence = '0;
  logic [7:0]  in_status_state = '0;
  logic [31:0] in_now_ms = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_op_ok;
  logic        out_is_ready;
  logic        out_command_code;
  logic [7:0]  out_chosen_mission;
  logic [15:0] out_intent_epoch;
  logic [31:0] out_cmd_time_ms;
  logic [31:0] out_accepted_count;
  logic [31:0] out_duplicate_count;
  logic [31:0] out_out_of_order_count;
  logic [31:0] out_mismatch_count;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the filter: configuration and client state
  cfg_t        filter_cfg;
  logic [7:0]  sel_mission;
  logic        cmd_is_start;
  logic [31:0] cmd_time;
  logic        started;
  logic        stat_valid;
  logic [7:0]  last_seq;
  logic [7:0]  last_state;
  logic [31:0] last_stat_time;
  logic [31:0] status_counts [4];

  res_t        pending_results [$];
  row_t        directed_rows [$];
  logic [31:0] ms_clock = 32'h0000_0020;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned failures = 0;
  int unsigned txn_count = 0;
  int unsigned cfg_settings = 1;

  mission_status_sequence_filter uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_mission_id          (in_mission_id),
    .in_status_epoch        (in_status_epoch),
    .in_status_sequence     (in_status_sequence),
    .in_status_state        (in_status_state),
    .in_now_ms              (in_now_ms),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_op_ok              (out_op_ok),
    .out_is_ready           (out_is_ready),
    .out_command_code       (out_command_code),
    .out_chosen_mission     (out_chosen_mission),
    .out_intent_epoch       (out_intent_epoch),
    .out_cmd_time_ms        (out_cmd_time_ms),
    .out_accepted_count     (out_accepted_count),
    .out_duplicate_count    (out_duplicate_count),
    .out_out_of_order_count (out_out_of_order_count),
    .out_mismatch_count     (out_mismatch_count),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #2 clk = ~clk;

  // ready: valid status, no start yet, ready code seen, age within limit (age wraps)
  function automatic logic ready_at_time(input logic [31:0] now);
    logic [31:0] age;
    age = now - last_stat_time;
    return stat_valid && !started && (last_state == filter_cfg.ready_state_code)
        && (age <= {16'd0, filter_cfg.fresh_limit_ms});
  endfunction

  // advance the shadow by one transaction and build the result it must produce
  function automatic res_t apply_transaction(input txn_t t);
    res_t       r;
    logic       ok;
    logic [7:0] delta;
    ok = 1'b0;
    case (t.op)
      OP_SELECT: begin
        if (!started && t.mission >= filter_cfg.min_mission_id
            && t.mission <= filter_cfg.max_mission_id) begin
          sel_mission = t.mission;
          cmd_is_start = 1'b0;
          cmd_time = t.now;
          stat_valid = 1'b0;
          ok = 1'b1;
        end
      end
      OP_STATUS: begin
        // epoch/mission check wins over the sequence filter
        delta = t.seq - last_seq;
        if (t.epoch != filter_cfg.session_epoch || t.mission != sel_mission) begin
          status_counts[CNT_MISMATCH] = status_counts[CNT_MISMATCH] + 32'd1;
        end else if (stat_valid && delta == 8'd0) begin
          status_counts[CNT_DUPLICATE] = status_counts[CNT_DUPLICATE] + 32'd1;
        end else if (stat_valid && delta[7]) begin
          status_counts[CNT_OUT_OF_ORDER] = status_counts[CNT_OUT_OF_ORDER] + 32'd1;
        end else begin
          last_seq = t.seq;
          last_state = t.state;
          last_stat_time = t.now;
          stat_valid = 1'b1;
          status_counts[CNT_ACCEPTED] = status_counts[CNT_ACCEPTED] + 32'd1;
          ok = 1'b1;
        end
      end
      OP_START: begin
        if (ready_at_time(t.now)) begin
          cmd_is_start = 1'b1;
          cmd_time = t.now;
          started = 1'b1;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.is_ready = ready_at_time(t.now);
    r.op_ok = (t.op == OP_QUERY) ? r.is_ready : ok;
    r.command_code = cmd_is_start;
    r.chosen_mission = sel_mission;
    r.intent_epoch = filter_cfg.session_epoch;
    r.cmd_time_ms = cmd_time;
    r.accepted_count = status_counts[CNT_ACCEPTED];
    r.duplicate_count = status_counts[CNT_DUPLICATE];
    r.out_of_order_count = status_counts[CNT_OUT_OF_ORDER];
    r.mismatch_count = status_counts[CNT_MISMATCH];
    return r;
  endfunction

  function automatic txn_t make_txn(input op_t op, input logic [7:0] mission,
                                    input logic [15:0] epoch, input logic [7:0] seq,
                                    input logic [7:0] state, input logic [31:0] now);
    txn_t t;
    t.op = op;
    t.mission = mission;
    t.epoch = epoch;
    t.seq = seq;
    t.state = state;
    t.now = now;
    return t;
  endfunction

  task automatic add_row(input op_t op, input logic [7:0] mission,
                         input logic [15:0] epoch, input logic [7:0] seq,
                         input logic [7:0] state, input logic [31:0] now,
                         input bit typed, input bit ok, input bit rdy);
    row_t row;
    row.t = make_txn(op, mission, epoch, seq, state, now);
    row.typed = typed;
    row.ok = ok;
    row.rdy = rdy;
    directed_rows.push_back(row);
  endtask

  // random traffic: mostly well-formed status streams for the chosen mission,
  // with duplicates, stale sequences, foreign epochs/missions and time jumps mixed in
  function automatic txn_t next_random_txn();
    txn_t        t;
    int unsigned pick;
    int unsigned r;
    t.op = OP_QUERY;
    t.mission = 8'($urandom);
    t.epoch = 16'($urandom);
    t.seq = 8'($urandom);
    t.state = 8'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      ms_clock = $urandom;
    end else begin
      ms_clock = ms_clock + $urandom_range(0, filter_cfg.fresh_limit_ms / 2 + 3);
    end
    t.now = ms_clock;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      t.op = OP_SELECT;
      if ($urandom_range(0, 3) != 0 && filter_cfg.min_mission_id <= filter_cfg.max_mission_id)
        t.mission = 8'($urandom_range(filter_cfg.min_mission_id,
                                      filter_cfg.max_mission_id));
    end else if (pick < 70) begin
      t.op = OP_STATUS;
      if ($urandom_range(0, 4) != 0) begin
        t.epoch = filter_cfg.session_epoch;
        t.mission = sel_mission;
        r = $urandom_range(0, 9);
        if (r == 0) t.seq = last_seq;                                  // duplicate
        else if (r == 1) t.seq = last_seq + 8'($urandom_range(128, 255)); // stale
        else t.seq = last_seq + 8'($urandom_range(1, (r == 9) ? 127 : 6));
        if ($urandom_range(0, 3) != 0) t.state = filter_cfg.ready_state_code;
      end
    end else if (pick < 80) begin
      // a granted start locks the client until reset, so only the tail may grant one
      t.op = ready_at_time(t.now) ? OP_QUERY : OP_START;
    end
    return t;
  endfunction

  // present one transaction, wait for acceptance, record what it must produce
  task automatic send_txn(input txn_t t, input bit typed, input bit ok, input bit rdy);
    res_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= t.op;
    in_mission_id <= t.mission;
    in_status_epoch <= t.epoch;
    in_status_sequence <= t.seq;
    in_status_state <= t.state;
    in_now_ms <= t.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_transaction(t);
    if (typed) begin
      r.op_ok = ok;
      r.is_ready = rdy;
    end
    pending_results.push_back(r);
    txn_count++;
    @(negedge clk);
  endtask

  // drop valid and let every outstanding result come back before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup cycle, access cycle, shadow updated at the completing edge
  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SESSION_EPOCH: filter_cfg.session_epoch = value[15:0];
      REG_FRESH_LIMIT:   filter_cfg.fresh_limit_ms = value[15:0];
      REG_READY_CODE:    filter_cfg.ready_state_code = value[7:0];
      REG_MIN_MISSION:   filter_cfg.min_mission_id = value[7:0];
      REG_MAX_MISSION:   filter_cfg.max_mission_id = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // bus goes idle between writes
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      failures++;
    end
  endtask

  // result side back-pressure in short random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transaction against the oldest outstanding expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        failures++;
      end else begin
        e = pending_results.pop_front();
        check_field("op_ok", 32'(e.op_ok), 32'(out_op_ok));
        check_field("is_ready", 32'(e.is_ready), 32'(out_is_ready));
        check_field("command_code", 32'(e.command_code), 32'(out_command_code));
        check_field("chosen_mission", 32'(e.chosen_mission), 32'(out_chosen_mission));
        check_field("intent_epoch", 32'(e.intent_epoch), 32'(out_intent_epoch));
        check_field("cmd_time_ms", e.cmd_time_ms, out_cmd_time_ms);
        check_field("accepted_count", e.accepted_count, out_accepted_count);
        check_field("duplicate_count", e.duplicate_count, out_duplicate_count);
        check_field("out_of_order_count", e.out_of_order_count, out_out_of_order_count);
        check_field("mismatch_count", e.mismatch_count, out_mismatch_count);
      end
    end
  end

  // watchdog: any handshake on any port counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[mission_status_sequence_filter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // shadow starts from the documented reset state
    filter_cfg.session_epoch = RST_SESSION_EPOCH;
    filter_cfg.fresh_limit_ms = RST_FRESH_LIMIT;
    filter_cfg.ready_state_code = RST_READY_CODE;
    filter_cfg.min_mission_id = RST_MIN_MISSION;
    filter_cfg.max_mission_id = RST_MAX_MISSION;
    sel_mission = DEFAULT_MISSION;
    cmd_is_start = 1'b0;
    cmd_time = '0;
    started = 1'b0;
    stat_valid = 1'b0;
    last_seq = '0;
    last_state = '0;
    last_stat_time = '0;
    foreach (status_counts[i]) status_counts[i] = '0;

    // directed rows under reset config: epoch 1, fresh 100, ready code 1, ids 1..8
    //        op         mis    epoch     seq    state  now           typed ok rdy
    add_row(OP_QUERY,  8'd0,   16'd0,    8'd0,   8'd0, 32'd0,          1, 0, 0); // after reset
    add_row(OP_START,  8'd2,   16'd1,    8'd0,   8'd1, 32'd5,          1, 0, 0); // no status yet
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd10,  8'd1, 32'd1000,       1, 1, 1); // first status
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd10,  8'd1, 32'd1001,       1, 0, 1); // duplicate
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd138, 8'd1, 32'd1002,       1, 0, 1); // delta 128
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd9,   8'd1, 32'd1003,       1, 0, 1); // delta 255
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd11,  8'd1, 32'd1050,       1, 1, 1);
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd138, 8'd0, 32'd1060,       1, 1, 0); // delta 127
    add_row(OP_STATUS, 8'd2,   16'd1,    8'd139, 8'd1, 32'd1070,       1, 1, 1);
    add_row(OP_STATUS, 8'd2,   16'd0,    8'd140, 8'd1, 32'd1071,       1, 0, 1); // wrong epoch
    add_row(OP_STATUS, 8'd3,   16'd1,    8'd140, 8'd1, 32'd1072,       1, 0, 1); // wrong mission
    add_row(OP_STATUS, 8'd2,   16'hFFFF, 8'd140, 8'd1, 32'd1073,       1, 0, 1);
    add_row(OP_QUERY,  8'd0,   16'd0,    8'd0,   8'd0, 32'd1170,       1, 1, 1); // age at limit
    add_row(OP_QUERY,  8'hFF,  16'hFFFF, 8'hFF,  8'hFF, 32'd1171,      1, 0, 0); // one past
    add_row(OP_QUERY,  8'd0,   16'd0,    8'd0,   8'd0, 32'd1069,       1, 0, 0); // age wraps
    add_row(OP_SELECT, 8'd0,   16'd0,    8'd0,   8'd0, 32'd2000,       1, 0, 0); // below min
    add_row(OP_SELECT, 8'd9,   16'd0,    8'd0,   8'd0, 32'd2000,       1, 0, 0); // above max
    add_row(OP_SELECT, 8'hFF,  16'hFFFF, 8'hFF,  8'hFF, 32'hFFFF_FFFF, 1, 0, 0);
    add_row(OP_SELECT, 8'd8,   16'd0,    8'd0,   8'd0, 32'd2000,       1, 1, 0); // max id
    add_row(OP_STATUS, 8'd8,   16'd1,    8'd139, 8'd1, 32'd2001,       1, 1, 1); // same seq ok
    add_row(OP_STATUS, 8'd8,   16'd1,    8'd140, 8'd1, 32'hFFFF_FFF0,  1, 1, 1);
    add_row(OP_QUERY,  8'd0,   16'd0,    8'd0,   8'd0, 32'h0000_0010,  1, 1, 1); // time wrap
    add_row(OP_SELECT, 8'd1,   16'd0,    8'd0,   8'd0, 32'h0000_0020,  1, 1, 0); // min id

    // synchronous reset, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_txn(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].ok,
               directed_rows[i].rdy);
    wait_idle();

    // register settings per phase, extremes first, then an empty id range, then a moderate setting
    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin
          write_register(REG_SESSION_EPOCH, 32'h0000_FFFF);
          write_register(REG_FRESH_LIMIT, 32'd0);
          write_register(REG_READY_CODE, 32'h0000_00FF);
          write_register(REG_MIN_MISSION, 32'd0);
          write_register(REG_MAX_MISSION, 32'h0000_00FF);
        end
        2: begin
          write_register(REG_SESSION_EPOCH, 32'd0);
          write_register(REG_FRESH_LIMIT, 32'h0000_FFFF);
          write_register(REG_READY_CODE, 32'd0);
          write_register(REG_MIN_MISSION, 32'h0000_00FF);
          write_register(REG_MAX_MISSION, 32'h0000_00FF);
        end
        3: begin
          // min above max: every select must be refused
          write_register(REG_SESSION_EPOCH, $urandom_range(0, 16'hFFFF));
          write_register(REG_FRESH_LIMIT, 32'd50);
          write_register(REG_READY_CODE, $urandom_range(0, 8'hFF));
          write_register(REG_MIN_MISSION, 32'd200);
          write_register(REG_MAX_MISSION, 32'd100);
        end
        default: begin
          write_register(REG_SESSION_EPOCH, 32'd1234);
          write_register(REG_FRESH_LIMIT, 32'd1000);
          write_register(REG_READY_CODE, 32'd5);
          write_register(REG_MIN_MISSION, 32'd0);
          write_register(REG_MAX_MISSION, 32'd15);
        end
      endcase
      cfg_settings++;
      // phase 3 runs without any idling on either side
      idle_on = (ph != 3);
      @(negedge clk);
      repeat (PHASE_ITEMS) send_txn(next_random_txn(), 0, 0, 0);
      wait_idle();
    end

    // tail: no idling; get ready, grant start, then everything runs locked
    idle_on = 1'b0;
    ms_clock = ms_clock + 32'd10;
    send_txn(make_txn(OP_SELECT, 8'd15, 16'd0, 8'd0, 8'd0, ms_clock), 0, 0, 0);
    send_txn(make_txn(OP_STATUS, 8'd15, filter_cfg.session_epoch, 8'($urandom),
                      filter_cfg.ready_state_code, ms_clock + 32'd1), 0, 0, 0);
    send_txn(make_txn(OP_START, 8'd0, 16'd0, 8'd0, 8'd0, ms_clock + 32'd2), 0, 0, 0);
    send_txn(make_txn(OP_SELECT, 8'd3, 16'd0, 8'd0, 8'd0, ms_clock + 32'd3), 0, 0, 0);
    ms_clock = ms_clock + 32'd3;
    repeat (TAIL_ITEMS) send_txn(next_random_txn(), 0, 0, 0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d transactions over %0d register settings, start granted: %0d",
             txn_count, cfg_settings, started);
    $display("status outcomes: %0d accepted, %0d duplicate, %0d out of order, %0d mismatched",
             status_counts[CNT_ACCEPTED], status_counts[CNT_DUPLICATE],
             status_counts[CNT_OUT_OF_ORDER], status_counts[CNT_MISMATCH]);
    if (failures == 0) begin
      $display("[mission_status_sequence_filter] OK");
    end else begin
      $display("[mission_status_sequence_filter] ERROR");
    end
    $finish;
  end

endmodule
